[src/rs_pkg.sv]
package rs_pkg;

    localparam int CW     = 20;
    localparam int SLOTS  = 4;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic signed [CW-1:0] t_c;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic [15:0]        a_w;
        logic [15:0]        a_h;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic [15:0]        b_w;
        logic [15:0]        b_h;
    } t_in;

    typedef struct packed {
        logic signed [15:0] piece_x;
        logic signed [15:0] piece_y;
        logic [15:0]        piece_w;
        logic [15:0]        piece_h;
        logic               is_last;
        logic               nothing_left;
    } t_out;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_piece;

    typedef struct packed {
        t_piece [SLOTS-1:0] piece;
        logic [SLOTS-1:0]   mask;
        logic               nothing;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    function automatic t_c sx(input logic [15:0] v);
        sx = {{(CW-16){v[15]}}, v};
    endfunction

    function automatic t_c zx(input logic [15:0] v);
        zx = {{(CW-16){1'b0}}, v};
    endfunction

    function automatic logic holds(input t_c rx, input t_c ry, input t_c rr, input t_c rb,
                                   input t_c px, input t_c py);
        holds = (px >= rx) && (px < rr) && (py >= ry) && (py < rb);
    endfunction

    function automatic t_piece mk(input t_c x, input t_c y, input t_c w, input t_c h);
        mk.x = x[15:0];
        mk.y = y[15:0];
        mk.w = w[15:0];
        mk.h = h[15:0];
    endfunction

    function automatic logic pos(input t_c w, input t_c h);
        pos = (w > t_c'(0)) && (h > t_c'(0));
    endfunction

endpackage

[src/rs_front.sv]
module rs_front
    import rs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  t_in    i_rects,
    input  t_qstat i_qstat,
    output logic   o_wr,
    output t_job   o_job
);

    logic r_s1_v, r_s2_v, r_s3_v;
    logic n_s1_v, n_s2_v, n_s3_v;
    logic s1_adv, s2_adv, s3_adv;

    t_in r_s1;
    t_c  r_s1_ar, r_s1_ab, r_s1_br, r_s1_bb;

    t_in  r_s2;
    t_c   r_s2_ar, r_s2_ab, r_s2_br, r_s2_bb;
    logic r_s2_top, r_s2_right, r_s2_bottom, r_s2_left;
    logic [3:0] r_s2_d;
    logic r_s2_vband, r_s2_hband;

    t_c   c_ax, c_ay, c_bx, c_by;
    logic c1, c2, c3, c4;

    t_in  r_s3;
    t_c   r_s3_br, r_s3_bb;
    t_c   r_s3_dyt, r_s3_hbot, r_s3_wl, r_s3_wr, r_s3_sy, r_s3_sh;
    logic r_s3_top, r_s3_right, r_s3_bottom, r_s3_left;
    logic [3:0] r_s3_d;
    logic r_s3_vband, r_s3_hband, r_s3_ah_gt;

    t_c n_sh;

    t_c   ax, ay, aw, ah;
    t_piece p_top, p_bot, p_lf, p_rf, p_ls, p_rs;
    logic v_top, v_bot, v_lf, v_rf, v_ls, v_rs;
    logic no_c;
    t_job job;

    assign s3_adv = !r_s3_v || !i_qstat.full;
    assign s2_adv = !r_s2_v || s3_adv;
    assign s1_adv = !r_s1_v || s2_adv;
    assign full   = !s1_adv;
    assign o_wr   = r_s3_v && !i_qstat.full;

    always_comb begin
        n_s1_v = s1_adv ? push : r_s1_v;
        n_s2_v = s2_adv ? r_s1_v : r_s2_v;
        n_s3_v = s3_adv ? r_s2_v : r_s3_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= n_s2_v;
            r_s3_v <= n_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1    <= i_rects;
            r_s1_ar <= sx(i_rects.a_x) + zx(i_rects.a_w);
            r_s1_ab <= sx(i_rects.a_y) + zx(i_rects.a_h);
            r_s1_br <= sx(i_rects.b_x) + zx(i_rects.b_w);
            r_s1_bb <= sx(i_rects.b_y) + zx(i_rects.b_h);
        end
    end

    always_comb begin
        c_ax = sx(r_s1.a_x);
        c_ay = sx(r_s1.a_y);
        c_bx = sx(r_s1.b_x);
        c_by = sx(r_s1.b_y);
        c1 = holds(c_ax, c_ay, r_s1_ar, r_s1_ab, c_bx, c_by);
        c2 = holds(c_ax, c_ay, r_s1_ar, r_s1_ab, r_s1_br - t_c'(1), c_by);
        c3 = holds(c_ax, c_ay, r_s1_ar, r_s1_ab, r_s1_br - t_c'(1), r_s1_bb - t_c'(1));
        c4 = holds(c_ax, c_ay, r_s1_ar, r_s1_ab, c_bx, r_s1_bb - t_c'(1));
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s2        <= r_s1;
            r_s2_ar     <= r_s1_ar;
            r_s2_ab     <= r_s1_ab;
            r_s2_br     <= r_s1_br;
            r_s2_bb     <= r_s1_bb;
            r_s2_top    <= c1 || c2;
            r_s2_right  <= c2 || c3;
            r_s2_bottom <= c3 || c4;
            r_s2_left   <= c4 || c1;
            r_s2_d[0]   <= holds(c_bx, c_by, r_s1_br, r_s1_bb, c_ax, c_ay);
            r_s2_d[1]   <= holds(c_bx, c_by, r_s1_br, r_s1_bb, r_s1_ar - t_c'(1), c_ay);
            r_s2_d[2]   <= holds(c_bx, c_by, r_s1_br, r_s1_bb,
                                 r_s1_ar - t_c'(1), r_s1_ab - t_c'(1));
            r_s2_d[3]   <= holds(c_bx, c_by, r_s1_br, r_s1_bb, c_ax, r_s1_ab - t_c'(1));
            r_s2_vband  <= (c_bx >= c_ax) && (c_bx < r_s1_ar) && (c_by < c_ay)
                           && (r_s1_bb >= r_s1_ab);
            r_s2_hband  <= (c_by >= c_ay) && (c_by < r_s1_ab) && (c_bx < c_ax)
                           && (r_s1_br >= r_s1_ar);
        end
    end

    always_comb begin
        priority if (r_s2_top && r_s2_bottom) begin
            n_sh = zx(r_s2.b_h);
        end else if (r_s2_bottom) begin
            n_sh = r_s2_bb - sx(r_s2.a_y);
        end else if (r_s2_top) begin
            n_sh = r_s2_ab - sx(r_s2.b_y);
        end else begin
            n_sh = zx(r_s2.a_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_s3        <= r_s2;
            r_s3_br     <= r_s2_br;
            r_s3_bb     <= r_s2_bb;
            r_s3_dyt    <= sx(r_s2.b_y) - sx(r_s2.a_y);
            r_s3_hbot   <= r_s2_ab - r_s2_bb;
            r_s3_wl     <= sx(r_s2.b_x) - sx(r_s2.a_x);
            r_s3_wr     <= r_s2_ar - r_s2_br;
            r_s3_sy     <= r_s2_top ? sx(r_s2.b_y) : sx(r_s2.a_y);
            r_s3_sh     <= n_sh;
            r_s3_top    <= r_s2_top;
            r_s3_right  <= r_s2_right;
            r_s3_bottom <= r_s2_bottom;
            r_s3_left   <= r_s2_left;
            r_s3_d      <= r_s2_d;
            r_s3_vband  <= r_s2_vband;
            r_s3_hband  <= r_s2_hband;
            r_s3_ah_gt  <= r_s2.a_h > r_s2.b_h;
        end
    end

    always_comb begin
        ax = sx(r_s3.a_x);
        ay = sx(r_s3.a_y);
        aw = zx(r_s3.a_w);
        ah = zx(r_s3.a_h);

        p_top = mk(ax, ay, aw, r_s3_dyt);
        p_bot = mk(ax, r_s3_bb, aw, r_s3_hbot);
        p_lf  = mk(ax, ay, r_s3_wl, ah);
        p_rf  = mk(r_s3_br, ay, r_s3_wr, ah);
        p_ls  = mk(ax, r_s3_sy, r_s3_wl, r_s3_sh);
        p_rs  = mk(r_s3_br, r_s3_sy, r_s3_wr, r_s3_sh);
        v_top = pos(aw, r_s3_dyt);
        v_bot = pos(aw, r_s3_hbot);
        v_lf  = pos(r_s3_wl, ah);
        v_rf  = pos(r_s3_wr, ah);
        v_ls  = pos(r_s3_wl, r_s3_sh);
        v_rs  = pos(r_s3_wr, r_s3_sh);

        no_c = !(r_s3_top || r_s3_right || r_s3_bottom || r_s3_left);

        job = '0;
        if (no_c) begin
            priority if (r_s3_d == 4'b1111) begin
                job.mask = '0;
            end else if (r_s3_d == 4'b0000) begin
                if (r_s3_vband || r_s3_hband) begin
                    if (r_s3_ah_gt) begin
                        job.piece[0] = p_top;
                        job.mask[0]  = v_top;
                        job.piece[1] = p_bot;
                        job.mask[1]  = v_bot;
                    end else begin
                        job.piece[0] = p_lf;
                        job.mask[0]  = v_lf;
                        job.piece[1] = p_rf;
                        job.mask[1]  = v_rf;
                    end
                end
            end else if (r_s3_d[0] && r_s3_d[3]) begin
                job.piece[0] = p_rf;
                job.mask[0]  = v_rf;
            end else if (r_s3_d[1] && r_s3_d[2]) begin
                job.piece[0] = p_lf;
                job.mask[0]  = v_lf;
            end else if (r_s3_d[0] && r_s3_d[1]) begin
                job.piece[0] = p_bot;
                job.mask[0]  = v_bot;
            end else begin
                job.piece[0] = p_top;
                job.mask[0]  = v_top;
            end
        end else begin
            job.piece[0] = p_top;
            job.mask[0]  = r_s3_top && v_top;
            job.piece[1] = p_bot;
            job.mask[1]  = r_s3_bottom && v_bot;
            job.piece[2] = p_ls;
            job.mask[2]  = r_s3_left && v_ls;
            job.piece[3] = p_rs;
            job.mask[3]  = r_s3_right && v_rs;
        end

        if (job.mask == '0) begin
            job.piece   = '0;
            job.mask    = SLOTS'(1);
            job.nothing = 1'b1;
        end
    end

    assign o_job = job;

endmodule

[src/rs_queue.sv]
module rs_queue
    import rs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_job   i_job,
    input  logic   i_rd,
    output t_qstat o_qstat,
    output t_job   o_head
);

    t_job r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_qstat.valid = r_cnt != '0;
    assign o_qstat.full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_head        = r_mem[r_rp];

    always_comb begin
        n_wp  = i_wr ? r_wp + 1'b1 : r_wp;
        n_rp  = i_rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[src/rs_back.sv]
module rs_back
    import rs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_qstat,
    input  t_job   i_head,
    output logic   o_rd,
    output logic   empty,
    input  logic   pop,
    output t_out   o_piece
);

    logic [SLOTS-1:0] r_done, n_done;
    logic [SLOTS-1:0] rem, sel;
    logic             last, emit;
    logic             r_out_v, n_out_v;
    t_out             r_out;
    t_piece           pick;

    always_comb begin
        rem  = i_head.mask & ~r_done;
        sel  = rem & (~rem + 1'b1);
        last = (rem & ~sel) == '0;
        emit = i_qstat.valid && (!r_out_v || pop);
        pick = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (sel[k]) begin
                pick = pick | i_head.piece[k];
            end
        end
        n_done  = emit ? (last ? '0 : (r_done | sel)) : r_done;
        n_out_v = emit ? 1'b1 : (pop ? 1'b0 : r_out_v);
    end

    assign o_rd    = emit && last;
    assign empty   = !r_out_v;
    assign o_piece = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.piece_x      <= pick.x;
            r_out.piece_y      <= pick.y;
            r_out.piece_w      <= pick.w;
            r_out.piece_h      <= pick.h;
            r_out.is_last      <= last;
            r_out.nothing_left <= i_head.nothing;
        end
    end

endmodule

[src/rectangle_subtract.sv]
// channel   direction  handshake            word
// rects     in         push / full          t_in  (rectangles A and B)
// pieces    out        empty / pop          t_out (one piece of A minus B)
//
// Path to empty falling: three front stages, the job queue and the output register.
// Throughput: one piece per cycle at the output register while a job waits and pop
// keeps up; an item gives one to four pieces. The front takes an item every cycle
// until the four-entry job queue fills; full then stalls the front stages back to
// the input.
// Reset is synchronous and clears valid flags, queue pointers and the emitted-piece mask.
module rectangle_subtract
    import rs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_rects,
    output logic empty,
    input  logic pop,
    output t_out o_piece
);

    t_qstat qstat;
    t_job   wr_job, head;
    logic   wr, rd;

    rs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_rects (i_rects),
        .i_qstat (qstat),
        .o_wr    (wr),
        .o_job   (wr_job)
    );

    rs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_job   (wr_job),
        .i_rd    (rd),
        .o_qstat (qstat),
        .o_head  (head)
    );

    rs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head),
        .o_rd    (rd),
        .empty   (empty),
        .pop     (pop),
        .o_piece (o_piece)
    );

endmodule

[tb/sv/rectangle_subtract_tb.sv]
`timescale 1ns / 1ps

module rectangle_subtract_tb
    import rs_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AT     = 120;
    localparam t_out NONE_LEFT = '{16'sd0, 16'sd0, 16'd0, 16'd0, 1'b1, 1'b1};

    typedef struct {
        longint x, y, w, h;
    } t_box;

    typedef struct {
        t_in  rects;
        bit   typed;
        t_out want;
    } t_plan_row;

    typedef enum {SH_INSIDE, SH_VBAND, SH_HBAND, SH_COVER, SH_NEAR} t_shape;
    typedef enum {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_MOSTLY} t_pop_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    t_in  i_rects = '0;
    logic pop     = 1'b0;
    logic full;
    logic empty;
    t_out o_piece;

    bit   cur_typed  = 1'b0;
    t_out cur_expect = '0;

    t_box      cuts[$];
    t_out      due_pieces[$];
    t_plan_row plan[$];

    int words_in     = 0;
    int pieces_seen  = 0;
    int empties_seen = 0;
    int mismatches   = 0;
    int cycles       = 0;
    int burst_left   = 0;

    rectangle_subtract i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_rects (i_rects),
        .empty   (empty),
        .pop     (pop),
        .o_piece (o_piece)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit cell_in(input t_box r, input longint px, input longint py);
        return px >= r.x && px < r.x + r.w && py >= r.y && py < r.y + r.h;
    endfunction

    function automatic void cut(input longint x, input longint y, input longint w,
                                input longint h);
        if (w > 0 && h > 0 && cuts.size() < 4) begin
            cuts.insert(cuts.size(), t_box'{x, y, w, h});
        end
    endfunction

    function automatic void expect_piece(input t_out p);
        due_pieces.insert(due_pieces.size(), p);
    endfunction

    function automatic void add_row(input t_in rects, input bit typed, input t_out want);
        t_plan_row row;
        row.rects = rects;
        row.typed = typed;
        row.want  = want;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void carve_pieces(input t_in r);
        t_box   a, b;
        longint ar, ab, br, bb, sy, sh;
        bit     c1, c2, c3, c4, on_top, on_right, on_bot, on_left;
        bit     d1, d2, d3, d4, vband, hband;
        t_out   w;
        cuts.delete();
        a = '{longint'($signed(r.a_x)), longint'($signed(r.a_y)),
              longint'(r.a_w), longint'(r.a_h)};
        b = '{longint'($signed(r.b_x)), longint'($signed(r.b_y)),
              longint'(r.b_w), longint'(r.b_h)};
        ar = a.x + a.w;
        ab = a.y + a.h;
        br = b.x + b.w;
        bb = b.y + b.h;
        c1 = cell_in(a, b.x, b.y);
        c2 = cell_in(a, br - 1, b.y);
        c3 = cell_in(a, br - 1, bb - 1);
        c4 = cell_in(a, b.x, bb - 1);
        on_top   = c1 || c2;
        on_right = c2 || c3;
        on_bot   = c3 || c4;
        on_left  = c4 || c1;
        if (!(on_top || on_right || on_bot || on_left)) begin
            d1 = cell_in(b, a.x, a.y);
            d2 = cell_in(b, ar - 1, a.y);
            d3 = cell_in(b, ar - 1, ab - 1);
            d4 = cell_in(b, a.x, ab - 1);
            if (!(d1 && d2 && d3 && d4)) begin
                if (!d1 && !d2 && !d3 && !d4) begin
                    vband = b.x >= a.x && b.x < ar && b.y < a.y && bb >= ab;
                    hband = b.y >= a.y && b.y < ab && b.x < a.x && br >= ar;
                    if (vband || hband) begin
                        if (a.h > b.h) begin
                            cut(a.x, a.y, a.w, b.y - a.y);
                            cut(a.x, bb, a.w, ab - bb);
                        end else begin
                            cut(a.x, a.y, b.x - a.x, a.h);
                            cut(br, a.y, ar - br, a.h);
                        end
                    end
                end else if (d1 && d4) begin
                    cut(br, a.y, ar - br, a.h);
                end else if (d2 && d3) begin
                    cut(a.x, a.y, b.x - a.x, a.h);
                end else if (d1 && d2) begin
                    cut(a.x, bb, a.w, ab - bb);
                end else begin
                    cut(a.x, a.y, a.w, b.y - a.y);
                end
            end
        end else begin
            if (on_top) begin
                cut(a.x, a.y, a.w, b.y - a.y);
            end
            if (on_bot) begin
                cut(a.x, bb, a.w, ab - bb);
            end
            if (on_left || on_right) begin
                sy = on_top ? b.y : a.y;
                if (on_top && on_bot) begin
                    sh = b.h;
                end else if (on_bot) begin
                    sh = bb - sy;
                end else begin
                    sh = ab - sy;
                end
                if (on_left) begin
                    cut(a.x, sy, b.x - a.x, sh);
                end
                if (on_right) begin
                    cut(br, sy, ar - br, sh);
                end
            end
        end
        if (cuts.size() == 0) begin
            expect_piece(NONE_LEFT);
        end else begin
            foreach (cuts[k]) begin
                w.piece_x      = 16'(cuts[k].x);
                w.piece_y      = 16'(cuts[k].y);
                w.piece_w      = 16'(cuts[k].w);
                w.piece_h      = 16'(cuts[k].h);
                w.is_last      = (k == cuts.size() - 1);
                w.nothing_left = 1'b0;
                expect_piece(w);
            end
        end
    endfunction

    function automatic t_in rect_pair(input int ax, input int ay, input int aw, input int ah,
                                      input int bx, input int by, input int bw, input int bh);
        t_in r;
        r.a_x = 16'(ax);
        r.a_y = 16'(ay);
        r.a_w = 16'(aw);
        r.a_h = 16'(ah);
        r.b_x = 16'(bx);
        r.b_y = 16'(by);
        r.b_w = 16'(bw);
        r.b_h = 16'(bh);
        return r;
    endfunction

    function automatic t_out lone_piece(input int x, input int y, input int w, input int h);
        return '{16'(x), 16'(y), 16'(w), 16'(h), 1'b1, 1'b0};
    endfunction

    function automatic t_in random_pair();
        t_in         r;
        logic [15:0] ox, oy;
        int          k;
        t_shape      shape;
        if ($urandom_range(0, 4) == 0) begin
            r = {$urandom, $urandom, $urandom, $urandom};
            return r;
        end
        ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
        oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
        r.a_x = ox;
        r.a_y = oy;
        r.a_w = 16'($urandom_range(0, 24));
        r.a_h = 16'($urandom_range(0, 24));
        if ($urandom_range(0, 15) == 0) begin
            r.a_w = 16'hFFFF - 16'($urandom_range(0, 3));
        end
        k = $urandom_range(0, 6);
        shape = t_shape'($urandom_range(0, 4));
        unique case (shape)
            SH_INSIDE: begin
                r.b_x = r.a_x + 16'($urandom_range(0, r.a_w % 32));
                r.b_y = r.a_y + 16'($urandom_range(0, r.a_h % 32));
                r.b_w = 16'($urandom_range(0, r.a_w % 32));
                r.b_h = 16'($urandom_range(0, r.a_h % 32));
            end
            SH_VBAND: begin
                r.b_x = r.a_x + 16'($urandom_range(0, r.a_w % 32));
                r.b_w = 16'($urandom_range(0, 6));
                r.b_y = r.a_y - 16'(k);
                r.b_h = r.a_h + 16'(k + $urandom_range(0, 6));
            end
            SH_HBAND: begin
                r.b_y = r.a_y + 16'($urandom_range(0, r.a_h % 32));
                r.b_h = 16'($urandom_range(0, 6));
                r.b_x = r.a_x - 16'(k);
                r.b_w = r.a_w + 16'(k + $urandom_range(0, 6));
            end
            SH_COVER: begin
                r.b_x = r.a_x - 16'(k);
                r.b_y = r.a_y - 16'($urandom_range(0, 6));
                r.b_w = r.a_w + 16'(k + $urandom_range(0, 6));
                r.b_h = r.a_h + 16'($urandom_range(0, 12));
            end
            default: begin
                r.b_x = r.a_x + 16'($urandom_range(0, 40) - 12);
                r.b_y = r.a_y + 16'($urandom_range(0, 40) - 12);
                r.b_w = 16'($urandom_range(0, 30));
                r.b_h = 16'($urandom_range(0, 30));
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic check_piece(input t_out got);
        t_out due;
        pieces_seen++;
        if (got.nothing_left) begin
            empties_seen++;
        end
        if (due_pieces.size() == 0) begin
            report_mismatch($sformatf("piece %h with none due", got));
            return;
        end
        due = due_pieces.pop_front();
        if (got.piece_x !== due.piece_x) begin
            report_mismatch($sformatf("piece_x got %0d want %0d", got.piece_x, due.piece_x));
        end
        if (got.piece_y !== due.piece_y) begin
            report_mismatch($sformatf("piece_y got %0d want %0d", got.piece_y, due.piece_y));
        end
        if (got.piece_w !== due.piece_w) begin
            report_mismatch($sformatf("piece_w got %0d want %0d", got.piece_w, due.piece_w));
        end
        if (got.piece_h !== due.piece_h) begin
            report_mismatch($sformatf("piece_h got %0d want %0d", got.piece_h, due.piece_h));
        end
        if (got.is_last !== due.is_last) begin
            report_mismatch($sformatf("is_last got %b want %b", got.is_last, due.is_last));
        end
        if (got.nothing_left !== due.nothing_left) begin
            report_mismatch($sformatf("nothing_left got %b want %b",
                                      got.nothing_left, due.nothing_left));
        end
    endtask

    task automatic idle_for(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic offer(input t_in r, input bit typed, input t_out want);
        push       <= 1'b1;
        i_rects    <= r;
        cur_typed  <= typed;
        cur_expect <= want;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 9));
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic drain();
        idle_for(1);
        wait (due_pieces.size() == 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                words_in++;
                if (cur_typed) begin
                    expect_piece(cur_expect);
                end else begin
                    carve_pieces(i_rects);
                end
            end
            if (pop && !empty) begin
                check_piece(o_piece);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d pieces due", due_pieces.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int        phase_left;
        bit        held;
        t_pop_mode mode;
        phase_left = 0;
        held       = 1'b0;
        mode       = POP_ALWAYS;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            // hold off long enough for the job queue to back up into full
            if (!held && words_in >= HOLD_AT) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (phase_left == 0) begin
                mode       = t_pop_mode'($urandom_range(0, 3));
                phase_left = $urandom_range(8, 60);
            end
            phase_left--;
            unique case (mode)
                POP_ALWAYS: pop <= 1'b1;
                POP_COIN:   pop <= ($urandom_range(0, 1) == 1);
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge i_clk);
        end
    end

    initial begin
        add_row(rect_pair(0, 0, 10, 10, 100, 100, 5, 5), 1'b1, NONE_LEFT);
        add_row(rect_pair(0, 0, 10, 10, -1, -1, 20, 20), 1'b1, NONE_LEFT);
        add_row(rect_pair(0, 0, 10, 10, 3, 3, 2, 2), 1'b0, '0);
        add_row(rect_pair(0, 0, 10, 10, 3, -5, 2, 20), 1'b0, '0);
        add_row(rect_pair(0, 0, 10, 10, -5, 3, 20, 2), 1'b0, '0);
        add_row(rect_pair(0, 0, 10, 10, -5, -5, 10, 20), 1'b1, lone_piece(5, 0, 5, 10));
        add_row(rect_pair(0, 0, 10, 10, 5, -5, 10, 20), 1'b1, lone_piece(0, 0, 5, 10));
        add_row(rect_pair(0, 0, 10, 10, -5, -5, 20, 10), 1'b1, lone_piece(0, 5, 10, 5));
        add_row(rect_pair(0, 0, 10, 10, -5, 5, 20, 10), 1'b1, lone_piece(0, 0, 10, 5));
        add_row(rect_pair(0, 0, 10, 10, 5, 5, 10, 10), 1'b0, '0);
        add_row(rect_pair(0, 0, 10, 10, 10, 0, 5, 10), 1'b1, NONE_LEFT);
        add_row(rect_pair(-32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535),
                1'b0, '0);
        add_row(rect_pair(32767, 32767, 65535, 65535, -32768, -32768, 65535, 65535),
                1'b0, '0);
        add_row(rect_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NONE_LEFT);
        add_row(rect_pair(-1, -1, 65535, 65535, -1, -1, 65535, 65535), 1'b0, '0);
        add_row(rect_pair(32000, 0, 1000, 10, 32100, 3, 2, 2), 1'b0, '0);
        add_row(rect_pair(5, 5, 0, 0, 5, 5, 3, 3), 1'b1, NONE_LEFT);
        add_row(rect_pair(5, 5, 0, 0, 3, 5, 2, 3), 1'b1, NONE_LEFT);
        add_row(rect_pair(0, 0, 10, 10, 3, 3, 0, 0), 1'b0, '0);
        add_row(rect_pair(0, 0, 0, 10, -5, -5, 20, 20), 1'b0, '0);
        add_row(rect_pair(0, 0, 100, 100, -32768, -32768, 65535, 65535), 1'b0, '0);
        add_row(rect_pair(0, 0, 1, 65535, -32768, 100, 65535, 5), 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            offer(plan[k].rects, plan[k].typed, plan[k].want);
            pace();
        end
        drain();

        for (int n = 0; n < 280; n++) begin
            offer(random_pair(), 1'b0, '0);
            // keep offering back to back across the receiver hold-off
            if (n < 80 || n > 160) begin
                pace();
            end
            if (n == 200) begin
                drain();
            end
        end
        drain();
        repeat (12) @(posedge i_clk);

        $display("covered %0d subtractions giving %0d pieces, %0d of them empty results,",
                 words_in, pieces_seen, empties_seen);
        $display("with bursty input, random pop stalls and one full-queue back-pressure stretch");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
